// File: src/hkr_pkg.sv
package hkr_pkg;

    localparam int FIELD_W = 5;

    typedef struct packed {
        logic [FIELD_W-1:0] plain_r0c0;
        logic [FIELD_W-1:0] plain_r0c1;
        logic [FIELD_W-1:0] plain_r1c0;
        logic [FIELD_W-1:0] plain_r1c1;
        logic [FIELD_W-1:0] cipher_r0c0;
        logic [FIELD_W-1:0] cipher_r0c1;
        logic [FIELD_W-1:0] cipher_r1c0;
        logic [FIELD_W-1:0] cipher_r1c1;
    } t_hkr_in;

    typedef struct packed {
        logic [FIELD_W-1:0] key_r0c0;
        logic [FIELD_W-1:0] key_r0c1;
        logic [FIELD_W-1:0] key_r1c0;
        logic [FIELD_W-1:0] key_r1c1;
        logic               invertible;
    } t_hkr_out;

    // load strobes for the two register stages of a modular reducer
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_red_en;

endpackage

// File: src/hkr_mod_red.sv
module hkr_mod_red #(
    parameter int MODULUS = 26,
    parameter int XW      = 11
) (
    input  logic                       i_clk,
    input  hkr_pkg::t_red_en           i_en,
    input  logic [XW-1:0]              i_x,
    output logic [$clog2(MODULUS)-1:0] o_r
);
    import hkr_pkg::*;

    localparam int MW = $clog2(MODULUS);
    localparam logic [XW-1:0] RECIP = XW'((2**XW) / MODULUS);
    localparam logic [XW-1:0] MOD_X = XW'(MODULUS);

    logic [2*XW-1:0] prod;
    logic [XW-1:0]   r_x;
    logic [XW-1:0]   r_q;
    logic [XW-1:0]   rem;
    logic [XW-1:0]   rem_c;
    logic [MW-1:0]   r_r;
    logic [MW-1:0]   n_r;

    // quotient estimate, at most one short of the true quotient
    assign prod = (2*XW)'(i_x) * (2*XW)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_x <= i_x;
            r_q <= prod[2*XW-1:XW];
        end
    end

    always_comb begin
        rem   = r_x - r_q * MOD_X;
        rem_c = (rem >= MOD_X) ? (rem - MOD_X) : rem;
        n_r   = rem_c[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_r <= n_r;
        end
    end

    assign o_r = r_r;

endmodule

// File: src/hill_key_recovery_2x2_mod26_unit.sv
// Hill cipher 2x2 key recovery from one known plaintext/ciphertext matrix pair.
// Input channel (i_valid/o_ready, i_data): one transaction carries the plaintext
// matrix P and the matching ciphertext matrix C, entries 0..31, reduced mod
// MODULUS on entry. Output channel (o_valid/i_ready, o_data): one transaction per
// input with K = inverse(P) * C mod MODULUS and the invertible flag; when det(P)
// has no inverse the flag is low and all key entries are zero.
// Pipeline: 12 register stages. Throughput: one transaction per cycle while the
// receiver takes results, set by the fully pipelined datapath (table lookups, two
// multipliers per lane and nine two-stage reciprocal reducers).
// Each stage loads whenever it is empty or the stage after it moves, so bubbles
// are squeezed out and input is taken while a finished result waits.
// When the receiver stalls, the output holds; stages fill up and o_ready drops
// only when every stage holds a transaction.
// Reset clears all stage valid bits; no result is presented until new input.
module hill_key_recovery_2x2_mod26_unit #(
    parameter int MODULUS = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hkr_pkg::t_hkr_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output hkr_pkg::t_hkr_out o_data
);
    import hkr_pkg::*;

    localparam int MW    = $clog2(MODULUS);
    localparam int DW    = 2*MW + 1;
    localparam int IW    = 2*MW;
    localparam int NSTG  = 12;
    localparam int TBL_N = 2**FIELD_W;

    function automatic logic [TBL_N*MW-1:0] f_red_tbl();
        logic [TBL_N*MW-1:0] t;
        t = '0;
        for (int i = 0; i < TBL_N; i++) begin
            t[i*MW +: MW] = MW'(i % MODULUS);
        end
        return t;
    endfunction

    function automatic logic [MODULUS*MW-1:0] f_inv_tbl();
        logic [MODULUS*MW-1:0] t;
        logic                  hit;
        t = '0;
        for (int d = 0; d < MODULUS; d++) begin
            hit = 1'b0;
            for (int x = 1; x < MODULUS; x++) begin
                if (!hit && ((d * x) % MODULUS) == 1) begin
                    t[d*MW +: MW] = MW'(x);
                    hit = 1'b1;
                end
            end
        end
        return t;
    endfunction

    localparam logic [TBL_N*MW-1:0]   RED_TBL = f_red_tbl();
    localparam logic [MODULUS*MW-1:0] INV_TBL = f_inv_tbl();

    // stage control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = {r_vld[NSTG-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    // stage 0: reduce entries
    logic [FIELD_W-1:0] p_in [4];
    logic [FIELD_W-1:0] c_in [4];
    logic [MW-1:0]      r_s0_p [4];
    logic [MW-1:0]      r_s0_c [4];

    always_comb begin
        p_in[0] = i_data.plain_r0c0;
        p_in[1] = i_data.plain_r0c1;
        p_in[2] = i_data.plain_r1c0;
        p_in[3] = i_data.plain_r1c1;
        c_in[0] = i_data.cipher_r0c0;
        c_in[1] = i_data.cipher_r0c1;
        c_in[2] = i_data.cipher_r1c0;
        c_in[3] = i_data.cipher_r1c1;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 4; k++) begin
                r_s0_p[k] <= RED_TBL[p_in[k]*MW +: MW];
                r_s0_c[k] <= RED_TBL[c_in[k]*MW +: MW];
            end
        end
    end

    // stage 1: negated off-diagonal entries and raw determinant
    logic [MW-1:0] neg01;
    logic [MW-1:0] neg10;
    logic [DW-1:0] det_raw;
    logic [DW-1:0] r_s1_det;
    logic [MW-1:0] r_s1_m [4];
    logic [MW-1:0] r_s1_c [4];

    always_comb begin
        neg01   = (r_s0_p[1] == '0) ? '0 : MW'(MODULUS - int'(r_s0_p[1]));
        neg10   = (r_s0_p[2] == '0) ? '0 : MW'(MODULUS - int'(r_s0_p[2]));
        det_raw = DW'(r_s0_p[0]) * DW'(r_s0_p[3]) + DW'(neg01) * DW'(r_s0_p[2]);
    end

    // r_s1_m holds the adjugate entries in row order
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_det  <= det_raw;
            r_s1_m[0] <= r_s0_p[3];
            r_s1_m[1] <= neg01;
            r_s1_m[2] <= neg10;
            r_s1_m[3] <= r_s0_p[0];
            r_s1_c    <= r_s0_c;
        end
    end

    // stages 2 and 3: determinant mod MODULUS
    t_red_en       det_en;
    logic [MW-1:0] det;
    logic [MW-1:0] r_s2_m [4];
    logic [MW-1:0] r_s2_c [4];
    logic [MW-1:0] r_s3_m [4];
    logic [MW-1:0] r_s3_c [4];

    assign det_en = '{en_a: en[2], en_b: en[3]};

    hkr_mod_red #(.MODULUS(MODULUS), .XW(DW)) u_det_red (
        .i_clk (i_clk),
        .i_en  (det_en),
        .i_x   (r_s1_det),
        .o_r   (det)
    );

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_m <= r_s1_m;
            r_s2_c <= r_s1_c;
        end
        if (en[3]) begin
            r_s3_m <= r_s2_m;
            r_s3_c <= r_s2_c;
        end
    end

    // stage 4: modular inverse of the determinant
    logic [MW-1:0] dinv;
    logic [MW-1:0] r_s4_dinv;
    logic          r_s4_ok;
    logic [MW-1:0] r_s4_m [4];
    logic [MW-1:0] r_s4_c [4];

    assign dinv = INV_TBL[det*MW +: MW];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_dinv <= dinv;
            r_s4_ok   <= (dinv != '0);
            r_s4_m    <= r_s3_m;
            r_s4_c    <= r_s3_c;
        end
    end

    // stage 5: scale adjugate
    logic [IW-1:0] r_s5_prod [4];
    logic          r_s5_ok;
    logic [MW-1:0] r_s5_c [4];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 4; k++) begin
                r_s5_prod[k] <= IW'(r_s4_m[k]) * IW'(r_s4_dinv);
            end
            r_s5_ok <= r_s4_ok;
            r_s5_c  <= r_s4_c;
        end
    end

    // stages 6 and 7: inverse entries mod MODULUS
    t_red_en       mid_en;
    logic [MW-1:0] inv [4];
    logic          r_s6_ok;
    logic          r_s7_ok;
    logic [MW-1:0] r_s6_c [4];
    logic [MW-1:0] r_s7_c [4];

    assign mid_en = '{en_a: en[6], en_b: en[7]};

    for (genvar g = 0; g < 4; g++) begin : g_inv_red
        hkr_mod_red #(.MODULUS(MODULUS), .XW(IW)) u_inv_red (
            .i_clk (i_clk),
            .i_en  (mid_en),
            .i_x   (r_s5_prod[g]),
            .o_r   (inv[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_ok <= r_s5_ok;
            r_s6_c  <= r_s5_c;
        end
        if (en[7]) begin
            r_s7_ok <= r_s6_ok;
            r_s7_c  <= r_s6_c;
        end
    end

    // stage 8: matrix product inverse(P) * C
    logic [DW-1:0] r_s8_sum [4];
    logic          r_s8_ok;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_sum[0] <= DW'(inv[0]) * DW'(r_s7_c[0]) + DW'(inv[1]) * DW'(r_s7_c[2]);
            r_s8_sum[1] <= DW'(inv[0]) * DW'(r_s7_c[1]) + DW'(inv[1]) * DW'(r_s7_c[3]);
            r_s8_sum[2] <= DW'(inv[2]) * DW'(r_s7_c[0]) + DW'(inv[3]) * DW'(r_s7_c[2]);
            r_s8_sum[3] <= DW'(inv[2]) * DW'(r_s7_c[1]) + DW'(inv[3]) * DW'(r_s7_c[3]);
            r_s8_ok     <= r_s7_ok;
        end
    end

    // stages 9 and 10: key entries mod MODULUS
    t_red_en       key_en;
    logic [MW-1:0] key [4];
    logic          r_s9_ok;
    logic          r_s10_ok;

    assign key_en = '{en_a: en[9], en_b: en[10]};

    for (genvar g = 0; g < 4; g++) begin : g_key_red
        hkr_mod_red #(.MODULUS(MODULUS), .XW(DW)) u_key_red (
            .i_clk (i_clk),
            .i_en  (key_en),
            .i_x   (r_s8_sum[g]),
            .o_r   (key[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_s9_ok <= r_s8_ok;
        end
        if (en[10]) begin
            r_s10_ok <= r_s9_ok;
        end
    end

    // stage 11: output register
    logic [MW+FIELD_W-1:0] key_ext [4];
    logic [FIELD_W-1:0]    key_fld [4];
    t_hkr_out              n_out;
    t_hkr_out              r_out;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            key_ext[k] = (MW+FIELD_W)'(key[k]);
            key_fld[k] = r_s10_ok ? key_ext[k][FIELD_W-1:0] : '0;
        end
        n_out.key_r0c0   = key_fld[0];
        n_out.key_r0c1   = key_fld[1];
        n_out.key_r1c0   = key_fld[2];
        n_out.key_r1c1   = key_fld[3];
        n_out.invertible = r_s10_ok;
    end

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// File: src/hkr_checker.sv
module hkr_checker #(
    parameter int MODULUS = 26
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input hkr_pkg::t_hkr_in  i_data,
    input logic              o_valid,
    input logic              i_ready,
    input hkr_pkg::t_hkr_out o_data
);
    import hkr_pkg::*;

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("input changed while stalled");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    // singular plaintext gives a zero key
    a_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.invertible |->
            o_data.key_r0c0 == '0 && o_data.key_r0c1 == '0 &&
            o_data.key_r1c0 == '0 && o_data.key_r1c1 == '0)
        else $error("nonzero key with singular plaintext");

    // key entries stay below the modulus when it fits the field
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (MODULUS <= 32) |->
            int'(o_data.key_r0c0) < MODULUS && int'(o_data.key_r0c1) < MODULUS &&
            int'(o_data.key_r1c0) < MODULUS && int'(o_data.key_r1c1) < MODULUS)
        else $error("key entry out of range");

    // pipeline takes input whenever the output side can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready)
        else $error("input stalled with a free pipeline");

endmodule

bind hill_key_recovery_2x2_mod26_unit hkr_checker #(.MODULUS(MODULUS)) u_hkr_checker (.*);
